// ===== rtl/bifd_pkg.sv =====
// Shared types and constants of the beam intensity frame decoder.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package bifd_pkg;

	localparam int TABLE_DEPTH    = 256;
	localparam int CODE_W         = 8;
	localparam int VAL_W          = 20;
	localparam int CORR_W         = 22;
	localparam int SUM_W          = 48;
	localparam int WORD_W         = 16;
	localparam int TURN_W         = 32;
	localparam int IDX_OUT_W      = 10;
	localparam int ENTRY_W        = CODE_W + VAL_W;
	localparam int HDR_WORDS      = 3;
	localparam int S_TDATA_W      = 48;
	localparam int M_TDATA_W      = 160;

	localparam logic [VAL_W-1:0]  BASELINE_RESET = 20'd66560;
	localparam logic [SUM_W-1:0]  SUM_MAX        = {SUM_W{1'b1}};

	// tuser codes of the input stream
	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	typedef struct packed {
		logic tbl_wr;     // write one conversion table entry
		logic word_load;  // take a stream word
		logic add_bucket; // convert, accumulate, store or latch reference
		logic next_lane;  // move to the high byte of the word
		logic emit_cur;   // emit the current bucket, corrected
		logic emit_ref;   // emit the reference bucket at baseline
		logic fl_emit;    // emit one held bucket
	} bifd_cmd_t;

	typedef struct packed {
		logic bucket_word; // word position is past the header
		logic skip_first;  // low-byte bucket is beyond the bucket count
		logic idx_lt_ref;
		logic idx_eq_ref;
		logic ref_zero;    // no buckets are held ahead of the reference
		logic lane_hi;
		logic next_skip;   // high-byte bucket is beyond the bucket count
		logic k_last;
		logic out_free;
	} bifd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bifd_ctrl.sv =====
// Controller state machine of the beam intensity frame decoder.
// Depends on bifd_pkg for the command and status structs.
`default_nettype none

module bifd_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_req_type,
	output logic                 in_ready,
	input  wire bifd_pkg::bifd_sts_t sts,
	output bifd_pkg::bifd_cmd_t  cmd
);
	import bifd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ADD,
		ST_EMIT,
		ST_FL_READ,
		ST_FL_EMIT,
		ST_REF_EMIT,
		ST_NEXT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.tbl_wr     = accept && (in_req_type == REQ_TABLE);
		cmd.word_load  = accept && (in_req_type == REQ_DATA);
		cmd.add_bucket = (state_q == ST_ADD);
		cmd.next_lane  = (state_q == ST_NEXT) && !sts.lane_hi && !sts.next_skip;
		cmd.emit_cur   = (state_q == ST_EMIT) && sts.out_free;
		cmd.emit_ref   = (state_q == ST_REF_EMIT) && sts.out_free;
		cmd.fl_emit    = (state_q == ST_FL_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.word_load && sts.bucket_word && !sts.skip_first)
						state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (sts.idx_lt_ref)
						state_q <= ST_NEXT;
					else if (sts.idx_eq_ref)
						state_q <= sts.ref_zero ? ST_REF_EMIT : ST_FL_READ;
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free)
						state_q <= ST_NEXT;
				end
				ST_FL_READ: begin
					state_q <= ST_FL_EMIT;
				end
				ST_FL_EMIT: begin
					if (sts.out_free)
						state_q <= sts.k_last ? ST_REF_EMIT : ST_FL_READ;
				end
				ST_REF_EMIT: begin
					if (sts.out_free)
						state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					state_q <= cmd.next_lane ? ST_READ : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bifd_datapath.sv =====
// Datapath of the beam intensity frame decoder: framing registers, conversion
// table, held-bucket store, running sum and output register. Depends on bifd_pkg.
`default_nettype none

module bifd_datapath #(
	parameter int FRAME_WORDS      = 297,
	parameter int BUCKETS          = 588,
	parameter int REFERENCE_BUCKET = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire bifd_pkg::bifd_cmd_t           cmd,
	output bifd_pkg::bifd_sts_t                sts,
	input  wire  [bifd_pkg::WORD_W-1:0]        in_word,
	input  wire  [bifd_pkg::CODE_W-1:0]        in_index,
	input  wire  [bifd_pkg::VAL_W-1:0]         in_value,
	input  wire                                cfg_wr_en,
	input  wire  [bifd_pkg::VAL_W-1:0]         cfg_wr_data,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [bifd_pkg::M_TDATA_W-1:0]     out_data,
	output logic                               out_last
);
	import bifd_pkg::*;

	localparam int POS_W = $clog2(FRAME_WORDS);
	localparam int IDX_A = $clog2(2 * FRAME_WORDS);
	localparam int IDX_B = $clog2(BUCKETS + 1);
	localparam int IDX_C = $clog2(REFERENCE_BUCKET + 2);
	localparam int IDX_AB = (IDX_A > IDX_B) ? IDX_A : IDX_B;
	localparam int IDX_W = (IDX_AB > IDX_C) ? IDX_AB : IDX_C;
	localparam int EST_DEPTH = (REFERENCE_BUCKET > 0) ? REFERENCE_BUCKET : 1;
	localparam int EADDR_W = (EST_DEPTH > 1) ? $clog2(EST_DEPTH) : 1;

	// configuration and framing state
	logic [VAL_W-1:0]   base_q;
	logic [POS_W-1:0]   pos_q;
	logic [WORD_W-1:0]  turn_hi_q;
	logic [TURN_W-1:0]  turn_q;
	logic [WORD_W-1:0]  cap_q;
	logic [VAL_W-1:0]   ref_q;
	logic [SUM_W-1:0]   sum_q;

	// current bucket
	logic [IDX_W-1:0]   idx_q;
	logic [CODE_W-1:0]  code_q;
	logic [CODE_W-1:0]  word_hi_q;
	logic               lane_q;
	logic [VAL_W-1:0]   raw_q;
	logic [EADDR_W-1:0] k_q;

	// memories
	logic [VAL_W-1:0]   tbl_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tbl_vld_q;
	logic [VAL_W-1:0]   tbl_rd_q;
	logic               tbl_rdv_q;
	logic [ENTRY_W-1:0] est_mem [EST_DEPTH];
	logic [ENTRY_W-1:0] est_rd_q;

	logic               out_valid_q;

	logic [WORD_W-1:0]  swapped;
	logic [IDX_W-1:0]   idx_base;
	logic [VAL_W-1:0]   raw;
	logic [SUM_W:0]     sum_ext;
	logic [IDX_W-1:0]   em_idx;
	logic [CODE_W-1:0]  em_code;
	logic [VAL_W-1:0]   em_raw;
	logic [CORR_W-1:0]  em_corr;
	logic               emit;

	assign swapped  = {in_word[7:0], in_word[15:8]};
	assign idx_base = (IDX_W'(pos_q) - IDX_W'(HDR_WORDS)) << 1;
	assign raw      = tbl_rdv_q ? tbl_rd_q : '0;
	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(raw);
	assign emit     = cmd.emit_cur || cmd.emit_ref || cmd.fl_emit;

	always_comb begin
		sts             = '0;
		sts.bucket_word = (pos_q >= POS_W'(HDR_WORDS));
		sts.skip_first  = (idx_base >= IDX_W'(BUCKETS));
		sts.idx_lt_ref  = (idx_q < IDX_W'(REFERENCE_BUCKET));
		sts.idx_eq_ref  = (idx_q == IDX_W'(REFERENCE_BUCKET));
		sts.ref_zero    = (REFERENCE_BUCKET == 0);
		sts.lane_hi     = lane_q;
		sts.next_skip   = (idx_q >= IDX_W'(BUCKETS - 1));
		sts.k_last      = (k_q == EADDR_W'(REFERENCE_BUCKET - 1));
		sts.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASELINE_RESET;
			pos_q     <= '0;
			turn_hi_q <= '0;
			turn_q    <= '0;
			cap_q     <= '0;
			ref_q     <= '0;
			sum_q     <= '0;
			lane_q    <= 1'b0;
			k_q       <= '0;
			tbl_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				base_q <= cfg_wr_data;
			if (cmd.tbl_wr)
				tbl_vld_q[in_index] <= 1'b1;
			if (cmd.word_load) begin
				if (pos_q == POS_W'(0))
					turn_hi_q <= swapped;
				else if (pos_q == POS_W'(1))
					turn_q <= {turn_hi_q, swapped};
				else if (pos_q == POS_W'(2))
					cap_q <= in_word;
				pos_q  <= (pos_q == POS_W'(FRAME_WORDS - 1)) ? '0 : pos_q + 1'b1;
				lane_q <= 1'b0;
			end
			if (cmd.next_lane)
				lane_q <= 1'b1;
			if (cmd.add_bucket) begin
				// saturate at the top of the 48-bit range
				sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
				if (sts.idx_eq_ref) begin
					ref_q <= raw;
					k_q   <= '0;
				end
			end
			if (cmd.fl_emit)
				k_q <= k_q + 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.word_load) begin
			idx_q     <= idx_base;
			code_q    <= in_word[7:0];
			word_hi_q <= in_word[15:8];
		end
		if (cmd.next_lane) begin
			idx_q  <= idx_q + 1'b1;
			code_q <= word_hi_q;
		end
		if (cmd.add_bucket)
			raw_q <= raw;
	end

	// conversion table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr)
			tbl_mem[in_index] <= in_value;
		tbl_rd_q  <= tbl_mem[code_q];
		tbl_rdv_q <= tbl_vld_q[code_q];
	end

	// held buckets ahead of the reference
	always_ff @(posedge clk) begin
		if (cmd.add_bucket && sts.idx_lt_ref)
			est_mem[idx_q[EADDR_W-1:0]] <= {code_q, raw};
		est_rd_q <= est_mem[k_q];
	end

	always_comb begin
		if (cmd.fl_emit) begin
			em_idx  = IDX_W'(k_q);
			em_code = est_rd_q[ENTRY_W-1:VAL_W];
			em_raw  = est_rd_q[VAL_W-1:0];
		end else begin
			em_idx  = idx_q;
			em_code = code_q;
			em_raw  = raw_q;
		end
		if (cmd.emit_ref)
			em_corr = CORR_W'(base_q);
		else
			em_corr = CORR_W'(em_raw) - CORR_W'(ref_q) + CORR_W'(base_q);
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data <= {4'b0, sum_q, cap_q, turn_q, em_corr, em_raw, em_code,
				em_idx[IDX_OUT_W-1:0]};
			out_last <= (em_idx == IDX_W'(BUCKETS - 1));
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/beam_intensity_frame_decoder_top.sv =====
// Header words and table writes are taken in the idle state; a bucket word holds the
// input while each of its buckets is read, added, emitted and advanced (held buckets skip
// the emit; only the low bucket is taken when the high one is out of range). Its first
// result is registered from the emit state. The reference bucket emits a burst, one
// store read and emit per held bucket, then itself at baseline, in place of its single emit.
// Output stalls hold the controller in every emit state. Reset (arst_n low) clears the table
// valid bits, framing and sum, and restores the baseline to 260.0.
`default_nettype none

module beam_intensity_frame_decoder_top #(
	parameter int FRAME_WORDS      = 297,
	parameter int BUCKETS          = 588,
	parameter int REFERENCE_BUCKET = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// data_word [15:0], table_index [23:16], table_value [43:24], zero [47:44]
	input  wire  [bifd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  wire                               s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// bucket_index [9:0], adc_code [17:10], raw_intensity [37:18],
	// corrected_intensity [59:38], turn_number [91:60], cap_id [107:92],
	// running_sum [155:108], zero [159:156]
	output logic [bifd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// last_of_frame
	output logic                              m_axis_tlast,
	input  wire                               cfg_wr_en,
	input  wire  [bifd_pkg::VAL_W-1:0]        cfg_wr_data
);
	import bifd_pkg::*;

	bifd_cmd_t cmd;
	bifd_sts_t sts;

	bifd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_req_type (s_axis_tuser),
		.in_ready    (s_axis_tready),
		.sts         (sts),
		.cmd         (cmd)
	);

	bifd_datapath #(
		.FRAME_WORDS      (FRAME_WORDS),
		.BUCKETS          (BUCKETS),
		.REFERENCE_BUCKET (REFERENCE_BUCKET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_word     (s_axis_tdata[15:0]),
		.in_index    (s_axis_tdata[23:16]),
		.in_value    (s_axis_tdata[43:24]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_last    (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/bifd_checker.sv =====
// Port-level checks of the beam intensity frame decoder, bound to the top.
// Depends on bifd_pkg and on the top level's port list.
`default_nettype none

module bifd_checker #(
	parameter int BUCKETS = 588
) (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [bifd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input wire                            m_axis_tlast
);
	import bifd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// tlast marks the final bucket only
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tdata[IDX_OUT_W-1:0] == IDX_OUT_W'(BUCKETS - 1))
		else $error("tlast on a bucket other than the last");

	// the running sum never decreases between adjacent results
	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) ##1 m_axis_tvalid |->
			m_axis_tdata[155:108] >= $past(m_axis_tdata[155:108]))
		else $error("running sum decreased");

endmodule

bind beam_intensity_frame_decoder_top bifd_checker #(
	.BUCKETS (BUCKETS)
) u_bifd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
